// ----- rtl/sac_pkg.sv -----
// Shared constants, types and helpers of the set-associative LRU cache.
package sac_pkg;

  localparam int TOTAL_LINES   = 256;
  localparam int MAX_WAYS      = 4;
  localparam int ADDR_BITS     = 31;
  localparam int LINE_BITS     = $clog2(TOTAL_LINES);
  localparam int WAY_BITS      = $clog2(MAX_WAYS);
  localparam int ROWS          = TOTAL_LINES / MAX_WAYS;
  localparam int ROW_BITS      = $clog2(ROWS);
  localparam int RANK_BITS     = WAY_BITS;
  localparam int CNT_BITS      = 32;
  localparam int LG_BITS       = 2;
  localparam int WAYS_CNT_BITS = WAY_BITS + 1;

  localparam logic [LG_BITS-1:0] MAX_LG = LG_BITS'(WAY_BITS);

  typedef struct packed {
    logic [ADDR_BITS-1:0] tag;
    logic [RANK_BITS-1:0] rank;
  } entry_t;

  typedef entry_t [MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]                en;
    logic [MAX_WAYS-1:0]                vld;
    logic [MAX_WAYS-1:0]                match;
    logic [MAX_WAYS-1:0][RANK_BITS-1:0] rank;
    logic [WAYS_CNT_BITS-1:0]           ways;
  } lru_in_t;

  typedef struct packed {
    logic                               hit;
    logic [WAY_BITS-1:0]                used;
    logic [MAX_WAYS-1:0][RANK_BITS-1:0] rank_next;
  } lru_out_t;

  function automatic logic [LG_BITS-1:0] eff_lg(input logic [LG_BITS-1:0] lg);
    return (lg > MAX_LG) ? MAX_LG : lg;
  endfunction

  // First line of the set: row in the upper bits, first column in the lower bits.
  function automatic logic [LINE_BITS-1:0] line_base(input logic [ADDR_BITS-1:0] a,
                                                     input logic [LG_BITS-1:0] lg);
    return LINE_BITS'(a[LINE_BITS-1:0] << lg);
  endfunction

endpackage

// ----- rtl/sac_ifs.sv -----
// Request and result channel interfaces of the set-associative LRU cache.
interface sac_req_if;
  logic                          valid;
  logic                          ready;
  logic [sac_pkg::ADDR_BITS-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface sac_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [sac_pkg::WAY_BITS-1:0] way_used;
  logic [sac_pkg::CNT_BITS-1:0] hit_total;
  logic [sac_pkg::CNT_BITS-1:0] miss_total;

  modport source (output valid, output hit, output way_used, output hit_total,
                  output miss_total, input ready);
  modport sink (input valid, input hit, input way_used, input hit_total,
                input miss_total, output ready);
endinterface

// ----- rtl/sac_lru.sv -----
// Hit detection, victim choice and recency update for the ways of one set.
module sac_lru (
  input  sac_pkg::lru_in_t  lru_i,
  output sac_pkg::lru_out_t lru_o
);

  always_comb begin
    logic                                found;
    logic                                empty;
    logic [sac_pkg::WAY_BITS-1:0]        used;
    logic [sac_pkg::RANK_BITS-1:0]       best;
    logic [sac_pkg::WAYS_CNT_BITS-1:0]   old_rank;
    found = 1'b0;
    empty = 1'b0;
    used  = '0;
    best  = '0;
    for (int w = 0; w < sac_pkg::MAX_WAYS; w++) begin
      if (!found && lru_i.en[w] && lru_i.vld[w] && lru_i.match[w]) begin
        found = 1'b1;
        used  = sac_pkg::WAY_BITS'(w);
      end
    end
    if (!found) begin
      for (int w = 0; w < sac_pkg::MAX_WAYS; w++) begin
        if (!empty && lru_i.en[w] && !lru_i.vld[w]) begin
          empty = 1'b1;
          used  = sac_pkg::WAY_BITS'(w);
        end
      end
      if (!empty) begin
        for (int w = 0; w < sac_pkg::MAX_WAYS; w++) begin
          if (lru_i.en[w] && lru_i.rank[w] > best) begin
            best = lru_i.rank[w];
            used = sac_pkg::WAY_BITS'(w);
          end
        end
      end
    end
    old_rank = (!found && empty) ? lru_i.ways
                                 : sac_pkg::WAYS_CNT_BITS'(lru_i.rank[used]);
    lru_o.hit  = found;
    lru_o.used = used;
    for (int w = 0; w < sac_pkg::MAX_WAYS; w++) begin
      if (sac_pkg::WAY_BITS'(w) == used) begin
        lru_o.rank_next[w] = '0;
      end else if (lru_i.vld[w] &&
                   sac_pkg::WAYS_CNT_BITS'(lru_i.rank[w]) < old_rank) begin
        lru_o.rank_next[w] = lru_i.rank[w] + 1'b1;
      end else begin
        lru_o.rank_next[w] = lru_i.rank[w];
      end
    end
  end

endmodule

// ----- rtl/set_assoc_cache_lru.sv -----
// 256-line set-associative cache model with LRU replacement, 1, 2 or 4 ways
// set by the ways_log2 register. Each address item returns one result item with hit/miss,
// the way used, and saturating hit and miss totals. Tags and recency ranks live in one
// 64-row memory, four lines to a row, read into a register as the item is taken and
// written back from the s1 stage when it advances, with forwarding when consecutive items
// touch the same row; valid bits are flip-flops. An item passes the s1 register and the
// output register; one item is taken per cycle while the result side keeps up. A register
// write clears all lines and keeps the totals; there is no clearing pass after reset.
module set_assoc_cache_lru (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sac_pkg::LG_BITS-1:0]  cfg_wdata,
  sac_req_if.sink                      req,
  sac_rsp_if.source                    rsp
);

  logic [sac_pkg::LG_BITS-1:0]     ways_log2;
  logic [sac_pkg::TOTAL_LINES-1:0] line_valid;
  sac_pkg::row_t                   mem [sac_pkg::ROWS];
  sac_pkg::row_t                   mem_q;
  sac_pkg::row_t                   fwd_row;
  logic                            fwd;
  logic                            s1_v;
  logic [sac_pkg::ADDR_BITS-1:0]   s1_addr;
  logic [sac_pkg::CNT_BITS-1:0]    hit_cnt, hit_cnt_next;
  logic [sac_pkg::CNT_BITS-1:0]    miss_cnt, miss_cnt_next;
  logic                            out_v;
  logic                            out_hit;
  logic [sac_pkg::WAY_BITS-1:0]    out_way;
  logic [sac_pkg::CNT_BITS-1:0]    out_hit_total;
  logic [sac_pkg::CNT_BITS-1:0]    out_miss_total;

  logic [sac_pkg::LG_BITS-1:0]     lg;
  logic                            adv;
  logic                            take;
  logic                            wr_en;
  logic [sac_pkg::LINE_BITS-1:0]   in_base;
  logic [sac_pkg::LINE_BITS-1:0]   s1_base;
  logic [sac_pkg::ROW_BITS-1:0]    in_row;
  logic [sac_pkg::ROW_BITS-1:0]    s1_row;
  sac_pkg::row_t                   row_cur;
  sac_pkg::row_t                   row_new;
  logic [sac_pkg::WAY_BITS-1:0]    used_col;
  sac_pkg::lru_in_t                lru_i;
  sac_pkg::lru_out_t               lru_o;

  assign lg        = sac_pkg::eff_lg(ways_log2);
  assign adv       = !out_v || rsp.ready;
  assign req.ready = !s1_v || adv;
  assign take      = req.valid && req.ready;
  assign wr_en     = s1_v && adv;
  assign in_base   = sac_pkg::line_base(req.address, lg);
  assign s1_base   = sac_pkg::line_base(s1_addr, lg);
  assign in_row    = in_base[sac_pkg::LINE_BITS-1:sac_pkg::WAY_BITS];
  assign s1_row    = s1_base[sac_pkg::LINE_BITS-1:sac_pkg::WAY_BITS];
  assign row_cur   = fwd ? fwd_row : mem_q;
  assign used_col  = s1_base[sac_pkg::WAY_BITS-1:0] | lru_o.used;

  always_comb begin
    logic [sac_pkg::WAY_BITS-1:0] col;
    col = '0;
    lru_i.ways = sac_pkg::WAYS_CNT_BITS'(1) << lg;
    for (int w = 0; w < sac_pkg::MAX_WAYS; w++) begin
      col = s1_base[sac_pkg::WAY_BITS-1:0] | sac_pkg::WAY_BITS'(w);
      lru_i.en[w]    = sac_pkg::WAYS_CNT_BITS'(w) < lru_i.ways;
      lru_i.vld[w]   = lru_i.en[w] && line_valid[{s1_row, col}];
      lru_i.match[w] = row_cur[col].tag == s1_addr;
      lru_i.rank[w]  = row_cur[col].rank;
    end
  end

  sac_lru u_lru (
    .lru_i (lru_i),
    .lru_o (lru_o)
  );

  always_comb begin
    logic [sac_pkg::WAY_BITS-1:0] col;
    col = '0;
    row_new = row_cur;
    for (int w = 0; w < sac_pkg::MAX_WAYS; w++) begin
      col = s1_base[sac_pkg::WAY_BITS-1:0] | sac_pkg::WAY_BITS'(w);
      if (lru_i.en[w]) begin
        row_new[col].rank = lru_o.rank_next[w];
      end
    end
    row_new[used_col].tag = s1_addr;
  end

  always_comb begin
    hit_cnt_next  = hit_cnt;
    miss_cnt_next = miss_cnt;
    if (lru_o.hit) begin
      if (hit_cnt != '1) begin
        hit_cnt_next = hit_cnt + 1'b1;
      end
    end else begin
      if (miss_cnt != '1) begin
        miss_cnt_next = miss_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_row] <= row_new;
    end
    if (take) begin
      mem_q   <= mem[in_row];
      fwd_row <= row_new;
      s1_addr <= req.address;
    end
    if (wr_en) begin
      out_hit        <= lru_o.hit;
      out_way        <= lru_o.used;
      out_hit_total  <= hit_cnt_next;
      out_miss_total <= miss_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_log2  <= '0;
      line_valid <= '0;
      fwd        <= 1'b0;
      s1_v       <= 1'b0;
      out_v      <= 1'b0;
      hit_cnt    <= '0;
      miss_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        ways_log2  <= cfg_wdata;
        line_valid <= '0;
      end else if (wr_en) begin
        line_valid[{s1_row, used_col}] <= 1'b1;
      end
      if (take) begin
        fwd  <= wr_en && (s1_row == in_row);
        s1_v <= 1'b1;
      end else if (adv) begin
        s1_v <= 1'b0;
      end
      if (adv) begin
        out_v <= s1_v;
      end
      if (wr_en) begin
        hit_cnt  <= hit_cnt_next;
        miss_cnt <= miss_cnt_next;
      end
    end
  end

  assign rsp.valid      = out_v;
  assign rsp.hit        = out_hit;
  assign rsp.way_used   = out_way;
  assign rsp.hit_total  = out_hit_total;
  assign rsp.miss_total = out_miss_total;

`ifndef SYNTH
  a_stall_holds_totals: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> ($stable(hit_cnt) && $stable(miss_cnt)))
    else $error("totals changed while result stalled");

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !cfg_we) |=> line_valid[$past({s1_row, used_col})])
    else $error("written line not valid");

  a_hit_on_valid: assert property (@(posedge clk) disable iff (rst)
    (s1_v && lru_o.hit) |-> lru_i.vld[lru_o.used])
    else $error("hit on invalid way");
`endif

endmodule
